[hdl/salc_pkg.sv]
package salc_pkg;

  // One cache line as it is kept in a set row of the tag memory.
  typedef struct packed {
    logic        vld;
    logic [31:0] tag;
  } line_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic commit;
  } dp_cmd_t;

  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_STORE  = 2'd1;
  localparam logic [1:0] KIND_MODIFY = 2'd2;
  localparam logic [1:0] KIND_FETCH  = 2'd3;

  localparam logic [1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [1:0] CFG_BLOCK_BITS = 2'd1;
  localparam logic [1:0] CFG_WAYS       = 2'd2;

  localparam logic [2:0] SET_BITS_RST   = 3'd4;
  localparam logic [4:0] BLOCK_BITS_RST = 5'd4;
  localparam logic [3:0] WAYS_RST       = 4'd1;

endpackage

[hdl/set_assoc_lru_cache_model.sv]
// Set-associative cache model with least-recently-used replacement.
// Input channel: in_valid/in_ready carry one access item, kind (load, store,
// modify or instruction fetch) and a 32-bit byte address. Output channel:
// out_valid/out_ready carry one result item per access, with the hits, miss
// and eviction of that access and the saturating running totals.
// Configuration: cfg_valid/cfg_ready write set_bits (index 0), block_bits
// (index 1) or ways (index 2); cfg_ready is always high. Write only while
// the block is idle.
// Sequence: an item is taken in the idle state and its set row is read from
// the tag memory into a register; in the lookup state, once the output
// register is free, the row is written back reordered (not for a fetch)
// and the result is registered. A new item is taken only after the last
// one has left the lookup state.
// Reset clears the totals and one valid bit per set row, so the cache reads
// as empty at once, and returns the configuration to its reset values. When
// the receiver stalls, the result is held in the output register and the
// block holds the next item in its lookup stage until the register frees up.
module set_assoc_lru_cache_model #(
  parameter int MAX_WAYS     = 8,
  parameter int MAX_SET_BITS = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [31:0] address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  hits_added,
  output logic        miss_added,
  output logic        evicted,
  output logic [31:0] total_hits,
  output logic [31:0] total_misses,
  output logic [31:0] total_evictions,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import salc_pkg::*;

  dp_cmd_t cmd;

  // Configuration is never held off.
  assign cfg_ready = 1'b1;

  salc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  salc_dp #(
    .MAX_WAYS     (MAX_WAYS),
    .MAX_SET_BITS (MAX_SET_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .kind            (kind),
    .address         (address),
    .hits_added      (hits_added),
    .miss_added      (miss_added),
    .evicted         (evicted),
    .total_hits      (total_hits),
    .total_misses    (total_misses),
    .total_evictions (total_evictions)
  );

endmodule

[hdl/salc_ram.sv]
module salc_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 2,
  parameter int ADDR_W = 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/salc_dp.sv]
module salc_dp #(
  parameter int MAX_WAYS     = 8,
  parameter int MAX_SET_BITS = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  salc_pkg::dp_cmd_t  cmd,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic [1:0]         kind,
  input  logic [31:0]        address,
  output logic [1:0]         hits_added,
  output logic               miss_added,
  output logic               evicted,
  output logic [31:0]        total_hits,
  output logic [31:0]        total_misses,
  output logic [31:0]        total_evictions
);
  import salc_pkg::*;

  localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int SETS   = 1 << MAX_SET_BITS;
  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int ROW_W  = MAX_WAYS * $bits(line_t);
  localparam logic [3:0] SB_MAX = 4'(MAX_SET_BITS);
  localparam logic [4:0] NW_MAX = 5'(MAX_WAYS);

  // Configuration registers.
  logic [2:0] set_bits;
  logic [4:0] block_bits;
  logic [3:0] ways;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits   <= SET_BITS_RST;
      block_bits <= BLOCK_BITS_RST;
      ways       <= WAYS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SET_BITS:   set_bits   <= cfg_data[2:0];
        CFG_BLOCK_BITS: block_bits <= cfg_data[4:0];
        CFG_WAYS:       ways       <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Clamped configuration.
  logic [3:0] sb;
  logic [4:0] nw;
  logic [4:0] nw_m1;
  logic [5:0] tag_shift;

  assign sb = ({1'b0, set_bits} > SB_MAX) ? SB_MAX : {1'b0, set_bits};
  assign nw = (ways == 4'd0) ? 5'd1 : (({1'b0, ways} > NW_MAX) ? NW_MAX : {1'b0, ways});
  assign nw_m1 = nw - 5'd1;
  assign tag_shift = {1'b0, block_bits} + {2'b00, sb};

  // Address split, done as the item is taken.
  logic [31:0] set_full;
  logic [31:0] tag_in;
  logic [SET_W-1:0] set_in;

  assign set_full = (address >> block_bits) & ~(32'hFFFF_FFFF << sb);
  assign set_in   = set_full[SET_W-1:0];
  assign tag_in   = (tag_shift < 6'd32) ? (address >> tag_shift[4:0]) : 32'd0;

  logic [SET_W-1:0] set_q;
  logic [31:0]      tag_q;
  logic [1:0]       kind_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      set_q  <= set_in;
      tag_q  <= tag_in;
      kind_q <= kind;
    end
  end

  // Tag memory, one row per set; rows not written since reset read as empty.
  logic [ROW_W-1:0] rd_row;
  logic [ROW_W-1:0] wr_row;
  logic [SETS-1:0]  row_vld;
  logic             is_fetch;

  assign is_fetch = (kind_q == KIND_FETCH);

  salc_ram #(
    .WIDTH  (ROW_W),
    .DEPTH  (SETS),
    .ADDR_W (SET_W)
  ) u_tags (
    .clk   (clk),
    .we    (cmd.commit && !is_fetch),
    .waddr (set_q),
    .wdata (wr_row),
    .re    (cmd.capture),
    .raddr (set_in),
    .rdata (rd_row)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
    end else if (cmd.commit && !is_fetch) begin
      row_vld[set_q] <= 1'b1;
    end
  end

  line_t [MAX_WAYS-1:0] raw;
  line_t [MAX_WAYS-1:0] cur;
  line_t [MAX_WAYS-1:0] upd;
  logic                 hit;
  logic [WAY_W-1:0]     found;

  assign raw = rd_row;

  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      cur[i]     = raw[i];
      cur[i].vld = raw[i].vld && row_vld[set_q];
    end
  end

  // Frontmost valid match among the ways in use.
  always_comb begin
    hit   = 1'b0;
    found = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (!hit && (5'(i) < nw) && cur[i].vld && (cur[i].tag == tag_q)) begin
        hit   = 1'b1;
        found = WAY_W'(i);
      end
    end
  end

  // Tag to the front; ways before a hit, or all on a miss, move back one.
  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (i == 0) begin
        upd[i].vld = 1'b1;
        upd[i].tag = tag_q;
      end else if (hit ? (WAY_W'(i) <= found) : (5'(i) < nw)) begin
        upd[i] = cur[i-1];
      end else begin
        upd[i] = cur[i];
      end
    end
  end

  assign wr_row = upd;

  // Per-item counts and saturating totals.
  logic [1:0]  hits_now;
  logic        miss_now;
  logic        evict_now;
  logic [31:0] hit_total;
  logic [31:0] miss_total;
  logic [31:0] eviction_total;
  logic [32:0] hit_sum;
  logic [32:0] miss_sum;
  logic [32:0] evict_sum;
  logic [31:0] hit_total_next;
  logic [31:0] miss_total_next;
  logic [31:0] eviction_total_next;

  always_comb begin
    hits_now  = 2'd0;
    miss_now  = 1'b0;
    evict_now = 1'b0;
    if (!is_fetch) begin
      if (hit) begin
        hits_now = (kind_q == KIND_MODIFY) ? 2'd2 : 2'd1;
      end else begin
        miss_now  = 1'b1;
        hits_now  = (kind_q == KIND_MODIFY) ? 2'd1 : 2'd0;
        evict_now = cur[nw_m1[WAY_W-1:0]].vld;
      end
    end
  end

  assign hit_sum   = {1'b0, hit_total} + {31'd0, hits_now};
  assign miss_sum  = {1'b0, miss_total} + {32'd0, miss_now};
  assign evict_sum = {1'b0, eviction_total} + {32'd0, evict_now};
  assign hit_total_next      = hit_sum[32]   ? 32'hFFFF_FFFF : hit_sum[31:0];
  assign miss_total_next     = miss_sum[32]  ? 32'hFFFF_FFFF : miss_sum[31:0];
  assign eviction_total_next = evict_sum[32] ? 32'hFFFF_FFFF : evict_sum[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_total      <= '0;
      miss_total     <= '0;
      eviction_total <= '0;
    end else if (cmd.commit) begin
      hit_total      <= hit_total_next;
      miss_total     <= miss_total_next;
      eviction_total <= eviction_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hits_added      <= hits_now;
      miss_added      <= miss_now;
      evicted         <= evict_now;
      total_hits      <= hit_total_next;
      total_misses    <= miss_total_next;
      total_evictions <= eviction_total_next;
    end
  end

endmodule

[hdl/salc_ctrl.sv]
module salc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output salc_pkg::dp_cmd_t cmd
);
  import salc_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LOOK = 1'b1;

  logic state;
  logic state_next;
  logic out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_LOOK;
        end
      end
      S_LOOK: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[hdl/salc_checker.sv]
module salc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  hits_added,
  input logic        miss_added,
  input logic        evicted,
  input logic [31:0] total_hits
);

  // A stalled result holds.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(total_hits) && $stable(hits_added))
    else $error("stalled result changed");

  // After an item is taken the block is busy with its lookup.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken during lookup");

  // An eviction only comes with a miss.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && evicted |-> miss_added)
    else $error("eviction without miss");

  // A miss counts at most the hit of a modify.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && miss_added |-> hits_added != 2'd2 && hits_added != 2'd3)
    else $error("too many hits on a miss");

endmodule

bind set_assoc_lru_cache_model salc_checker u_salc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .hits_added (hits_added),
  .miss_added (miss_added),
  .evicted    (evicted),
  .total_hits (total_hits)
);

[verif/set_assoc_lru_cache_model_test.sv]
module set_assoc_lru_cache_model_test;
  import salc_pkg::*;

  // The cache geometry that the block is built with. The predictor uses the
  // same caps when it clamps the configuration registers.
  localparam int MAX_WAYS     = 8;
  localparam int MAX_SET_BITS = 6;
  localparam int LINE_SLOTS   = (1 << MAX_SET_BITS) * MAX_WAYS;

  // Index 3 of the configuration port selects no register. Writes to it must
  // leave the cache and the configuration untouched.
  localparam logic [1:0] CFG_SPARE = 2'd3;

  localparam int FIXED_PHASES    = 8;
  localparam int PHASES          = 16;
  localparam int ITEMS_PER_PHASE = 115;

  // One result item, with the fields named as the output ports are.
  typedef struct packed {
    logic [1:0]  hits_added;
    logic        miss_added;
    logic        evicted;
    logic [31:0] total_hits;
    logic [31:0] total_misses;
    logic [31:0] total_evictions;
  } outcome_t;

  // One row of the directed table. Where typed is set, the expected result
  // is written in the row. Otherwise the predictor supplies it.
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] address;
    logic        typed;
    outcome_t    want;
  } access_row_t;

  typedef struct packed {
    logic [2:0] set_bits;
    logic [4:0] block_bits;
    logic [3:0] ways;
  } geometry_t;

  // The directed part runs at the reset geometry: 16 sets, 16-byte blocks
  // and one way, so every miss into a filled set evicts. The first rows
  // cover a cold miss, a hit inside the same block, an ignored fetch at the
  // top address, a store miss, a modify hit, a modify miss that evicts and
  // a load that evicts again.
  localparam access_row_t DIRECTED [13] = '{
    '{KIND_LOAD,   32'h0000_0000, 1'b1, '{2'd0, 1'b1, 1'b0, 32'd0, 32'd1, 32'd0}},
    '{KIND_LOAD,   32'h0000_000F, 1'b1, '{2'd1, 1'b0, 1'b0, 32'd1, 32'd1, 32'd0}},
    '{KIND_FETCH,  32'hFFFF_FFFF, 1'b1, '{2'd0, 1'b0, 1'b0, 32'd1, 32'd1, 32'd0}},
    '{KIND_STORE,  32'hFFFF_FFFF, 1'b1, '{2'd0, 1'b1, 1'b0, 32'd1, 32'd2, 32'd0}},
    '{KIND_MODIFY, 32'hFFFF_FFFF, 1'b1, '{2'd2, 1'b0, 1'b0, 32'd3, 32'd2, 32'd0}},
    '{KIND_MODIFY, 32'h0000_0100, 1'b1, '{2'd1, 1'b1, 1'b1, 32'd4, 32'd3, 32'd1}},
    '{KIND_LOAD,   32'h0000_0000, 1'b1, '{2'd0, 1'b1, 1'b1, 32'd4, 32'd4, 32'd2}},
    '{KIND_STORE,  32'h8000_0000, 1'b0, '0},
    '{KIND_LOAD,   32'h7FFF_FFF0, 1'b0, '0},
    '{KIND_FETCH,  32'h1234_5678, 1'b0, '0},
    '{KIND_MODIFY, 32'hAAAA_AAAA, 1'b0, '0},
    '{KIND_LOAD,   32'h5555_5555, 1'b0, '0},
    '{KIND_STORE,  32'hAAAA_AAAA, 1'b0, '0}
  };

  // The geometries of the first phases are the corners: the smallest cache,
  // the largest one, every register at its all-ones value (set bits and
  // ways past their caps), ways at zero, and splits so wide that the tag or
  // the set index falls off the top of the address. The later phases draw
  // geometries at random.
  localparam geometry_t FIXED_GEOMETRY [FIXED_PHASES] = '{
    '{3'd0, 5'd0,  4'd1},
    '{3'd6, 5'd26, 4'd8},
    '{3'd7, 5'd31, 4'd15},
    '{3'd0, 5'd31, 4'd0},
    '{3'd6, 5'd28, 4'd9},
    '{3'd2, 5'd30, 4'd3},
    '{3'd6, 5'd0,  4'd8},
    '{3'd1, 5'd3,  4'd2}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  kind = KIND_LOAD;
  logic [31:0] address = '0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic [1:0]  hits_added;
  logic        miss_added;
  logic        evicted;
  logic [31:0] total_hits;
  logic [31:0] total_misses;
  logic [31:0] total_evictions;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_SET_BITS;
  logic [7:0]  cfg_data = '0;

  // Random idling is switched off for some phases and for the last one.
  logic        idle_on = 1'b1;
  int          stall_left = 0;
  int          mismatches = 0;

  // The predictor's copy of the configuration registers.
  logic [2:0]  sets_log2   = SET_BITS_RST;
  logic [4:0]  offset_bits = BLOCK_BITS_RST;
  logic [3:0]  assoc       = WAYS_RST;

  // The predictor's copy of the cache. Each set owns MAX_WAYS slots, most
  // recently used first. A tag is only looked at while its valid bit is set.
  logic [31:0] line_tag   [LINE_SLOTS];
  bit          line_valid [LINE_SLOTS];
  logic [31:0] hit_count      = '0;
  logic [31:0] miss_count     = '0;
  logic [31:0] eviction_count = '0;

  // Results that the block still owes, oldest first.
  outcome_t    pending_outcomes [$];

  // Line addresses that a phase keeps revisiting, so that hits, reordering
  // within a set and evictions all happen often.
  logic [31:0] line_pool [$];

  set_assoc_lru_cache_model #(
    .MAX_WAYS(MAX_WAYS),
    .MAX_SET_BITS(MAX_SET_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .kind(kind),
    .address(address),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .hits_added(hits_added),
    .miss_added(miss_added),
    .evicted(evicted),
    .total_hits(total_hits),
    .total_misses(total_misses),
    .total_evictions(total_evictions),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Runs one access through the cache copy and returns the result that the
  // block must produce for it. The set index and tag are cut from a 64-bit
  // copy of the address, so a split that reaches past bit 31 yields zero.
  function automatic outcome_t lru_access(input logic [1:0] k, input logic [31:0] a);
    int unsigned sb;
    int unsigned nw;
    int unsigned setidx;
    int unsigned base;
    int unsigned found;
    int unsigned i;
    logic [63:0] wide;
    logic [31:0] tag;
    logic [32:0] sum;
    bit          hit;
    outcome_t    r;
    r = '0;
    if (k != KIND_FETCH) begin
      sb = (sets_log2 > MAX_SET_BITS) ? MAX_SET_BITS : sets_log2;
      nw = (assoc == 0) ? 1 : ((assoc > MAX_WAYS) ? MAX_WAYS : assoc);
      wide = {32'd0, a} >> offset_bits;
      setidx = wide[31:0] & ((32'd1 << sb) - 32'd1);
      wide = {32'd0, a} >> (offset_bits + sb);
      tag = wide[31:0];
      base = setidx * MAX_WAYS;
      hit = 1'b0;
      found = 0;
      // The valid line nearest the front wins when several match, which
      // can happen after the way count has been changed.
      for (i = 0; i < nw; i++) begin
        if (!hit && line_valid[base + i] && line_tag[base + i] == tag) begin
          hit = 1'b1;
          found = i;
        end
      end
      if (hit) begin
        r.hits_added = (k == KIND_MODIFY) ? 2'd2 : 2'd1;
        for (i = found; i > 0; i--) begin
          line_tag[base + i]   = line_tag[base + i - 1];
          line_valid[base + i] = line_valid[base + i - 1];
        end
      end else begin
        // A modify that misses still counts its store half as a hit.
        r.miss_added = 1'b1;
        r.hits_added = (k == KIND_MODIFY) ? 2'd1 : 2'd0;
        r.evicted = line_valid[base + nw - 1];
        for (i = nw - 1; i > 0; i--) begin
          line_tag[base + i]   = line_tag[base + i - 1];
          line_valid[base + i] = line_valid[base + i - 1];
        end
      end
      line_tag[base] = tag;
      line_valid[base] = 1'b1;
      // The totals stick at all ones instead of wrapping.
      sum = {1'b0, hit_count} + {31'd0, r.hits_added};
      hit_count = sum[32] ? '1 : sum[31:0];
      sum = {1'b0, miss_count} + {32'd0, r.miss_added};
      miss_count = sum[32] ? '1 : sum[31:0];
      sum = {1'b0, eviction_count} + {32'd0, r.evicted};
      eviction_count = sum[32] ? '1 : sum[31:0];
    end
    r.total_hits = hit_count;
    r.total_misses = miss_count;
    r.total_evictions = eviction_count;
    return r;
  endfunction

  // Offers one access item, maybe after a short gap, and holds it until the
  // block takes it. The expected result is queued at the edge of acceptance.
  task automatic send_access(input logic [1:0] k, input logic [31:0] a,
                             input logic typed, input outcome_t want);
    int       gap;
    outcome_t predicted;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    address <= a;
    do @(posedge clk); while (!in_ready);
    predicted = lru_access(k, a);
    pending_outcomes.push_back(typed ? want : predicted);
  endtask

  // Writes one configuration register and mirrors it in the predictor. The
  // caller lowers cfg_valid after its last write.
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SET_BITS:   sets_log2 = data[2:0];
      CFG_BLOCK_BITS: offset_bits = data[4:0];
      CFG_WAYS:       assoc = data[3:0];
      default: ;
    endcase
  endtask

  // The receiver stalls at random while idling is on.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Every result item taken from the block is checked against the oldest
  // expectation, field by field.
  always @(posedge clk) begin : result_check
    outcome_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_outcomes.size() == 0) begin
        $error("result item arrived with no access outstanding");
        mismatches++;
      end else begin
        want = pending_outcomes.pop_front();
        if (hits_added !== want.hits_added) begin
          $error("hits_added: expected %0d, got %0d", want.hits_added, hits_added);
          mismatches++;
        end
        if (miss_added !== want.miss_added) begin
          $error("miss_added: expected %0d, got %0d", want.miss_added, miss_added);
          mismatches++;
        end
        if (evicted !== want.evicted) begin
          $error("evicted: expected %0d, got %0d", want.evicted, evicted);
          mismatches++;
        end
        if (total_hits !== want.total_hits) begin
          $error("total_hits: expected %0d, got %0d", want.total_hits, total_hits);
          mismatches++;
        end
        if (total_misses !== want.total_misses) begin
          $error("total_misses: expected %0d, got %0d", want.total_misses, total_misses);
          mismatches++;
        end
        if (total_evictions !== want.total_evictions) begin
          $error("total_evictions: expected %0d, got %0d",
                 want.total_evictions, total_evictions);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    int          n_sets;
    int          n_tags;
    int unsigned sbe;
    logic [31:0] set_v;
    logic [31:0] addr_v;
    logic [31:0] offs_mask;
    logic [63:0] wide_v;
    geometry_t   g;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[r]) begin
      send_access(DIRECTED[r].kind, DIRECTED[r].address, DIRECTED[r].typed,
                  DIRECTED[r].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      // Some phases run without any idling, and so does the last one.
      idle_on <= (p % 5 != 3) && (p != PHASES - 1);

      // The registers may only change while the block is idle, so drain
      // every owed result first. The cache contents carry over.
      in_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clk);
      repeat (2) @(posedge clk);

      if (p < FIXED_PHASES) begin
        g = FIXED_GEOMETRY[p];
      end else begin
        g.set_bits = 3'($urandom_range(0, 7));
        g.block_bits = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                   : 5'($urandom_range(0, 10));
        g.ways = 4'($urandom_range(0, 15));
      end
      // The unused upper data bits carry noise that the block must drop.
      write_reg(CFG_SET_BITS, {5'($urandom), g.set_bits});
      write_reg(CFG_BLOCK_BITS, {3'($urandom), g.block_bits});
      write_reg(CFG_WAYS, {4'($urandom), g.ways});
      if ($urandom_range(0, 2) == 0) begin
        write_reg(CFG_SPARE, 8'($urandom));
      end
      cfg_valid <= 1'b0;

      // Build a pool of lines that crowd a few sets, some with more tags
      // than there are ways, so that hits, reordering and evictions mix.
      line_pool.delete();
      sbe = (sets_log2 > MAX_SET_BITS) ? MAX_SET_BITS : sets_log2;
      n_sets = $urandom_range(1, 3);
      for (int s = 0; s < n_sets; s++) begin
        set_v = $urandom & ((32'd1 << sbe) - 32'd1);
        n_tags = $urandom_range(1, 10);
        for (int t = 0; t < n_tags; t++) begin
          wide_v = ({32'd0, 32'($urandom)} << (offset_bits + sbe))
                 | ({32'd0, set_v} << offset_bits);
          line_pool.push_back(wide_v[31:0]);
        end
      end
      wide_v = (64'd1 << offset_bits) - 64'd1;
      offs_mask = wide_v[31:0];

      // Most items revisit a pooled line at a random byte within the block.
      // The rest land anywhere in the address space.
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if ($urandom_range(0, 4) == 0) begin
          addr_v = $urandom;
        end else begin
          addr_v = line_pool[$urandom_range(0, line_pool.size() - 1)]
                 | ($urandom & offs_mask);
        end
        send_access(2'($urandom), addr_v, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // A run that hangs on a handshake ends here.
  initial begin : watchdog
    #3_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

[filelist.f]
hdl/salc_pkg.sv
hdl/salc_ram.sv
hdl/salc_dp.sv
hdl/salc_ctrl.sv
hdl/set_assoc_lru_cache_model.sv
hdl/salc_checker.sv
verif/set_assoc_lru_cache_model_test.sv
